// ===== design/kalman_cv_tracker_2d_unit_defines.svh =====
// Assertion macros shared by the tracker checker.
// No dependencies; pulled in by the checker file only.
`ifndef KALMAN_CV_TRACKER_2D_UNIT_DEFINES_SVH
`define KALMAN_CV_TRACKER_2D_UNIT_DEFINES_SVH

// Clocked assertion, muted while reset is asserted
`define KCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset
`define KCT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/kct_pkg.sv =====
// Shared constants, types and fixed-point helpers for the 2D tracker.
// No dependencies; imported by every tracker module.
`default_nettype none

package kct_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS  = 6;

	// Action codes
	localparam logic [1:0] ACT_INIT    = 2'd0;
	localparam logic [1:0] ACT_PREDICT = 2'd1;
	localparam logic [1:0] ACT_UPDATE  = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_INIT_POS = 3'd0;
	localparam logic [2:0] REG_INIT_VEL = 3'd1;
	localparam logic [2:0] REG_PROC_POS = 3'd2;
	localparam logic [2:0] REG_PROC_VEL = 3'd3;
	localparam logic [2:0] REG_MEAS_X   = 3'd4;
	localparam logic [2:0] REG_MEAS_Y   = 3'd5;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               start;
		logic signed [63:0] num;
		logic signed [63:0] den;
	} kct_div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} kct_div_rsp_t;

	// Saturate a wide sum to 32 signed bits
	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return S32_MAX;
		else if (v < -66'sd2147483648)
			return S32_MIN;
		else
			return v[31:0];
	endfunction

	// Saturate symmetrically to +-(2^31-1)
	function automatic logic signed [31:0] satsym(input logic signed [32:0] v);
		if (v > 33'sd2147483647)
			return S32_MAX;
		else if (v < -33'sd2147483647)
			return -S32_MAX;
		else
			return v[31:0];
	endfunction

	// Round a raw product to nearest, ties toward plus infinity
	function automatic logic signed [63:0] mq(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p + (64'sd1 <<< (FRAC_BITS - 1));
		return s >>> FRAC_BITS;
	endfunction

	// Register value used as a signed quantity, clamped to the positive range
	function automatic logic signed [31:0] reg_val(input logic [31:0] r);
		return r[31] ? S32_MAX : signed'(r);
	endfunction

endpackage

`default_nettype wire

// ===== design/kct_mul.sv =====
// Shared 32x32 signed multiplier with a registered full product.
// Depends on kct_pkg.
`default_nettype none

module kct_mul
	import kct_pkg::*;
(
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [63:0]      prod
);

	logic signed [63:0] prod_q;

	// Register the exact product
	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ===== design/kct_div.sv =====
// Bit-serial restoring divider for the gain: round(n * 2^F / d), saturated.
// Depends on kct_pkg; one quotient bit per cycle, one division at a time.
`default_nettype none

module kct_div
	import kct_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire kct_div_req_t req,
	output kct_div_rsp_t      rsp
);

	typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_END} dstate_t;

	dstate_t     state_q;
	logic        neg_q;
	logic        ovf_q;
	logic [63:0] nm_q;
	logic [63:0] dm_q;
	logic [64:0] rem_q;
	logic [31:0] sh_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;

	logic [95:0] num_w;
	logic [95:0] lim_w;
	logic [64:0] rem_sh;
	logic [32:0] q_rnd;
	logic [31:0] q_neg;

	assign num_w  = 96'(nm_q) << (FRAC_BITS + 1);
	assign lim_w  = 96'(dm_q) << (31 - FRAC_BITS);
	assign rem_sh = {rem_q[63:0], sh_q[31]};
	assign q_rnd  = (33'(quo_q) + 33'd1) >> 1;
	assign q_neg  = ~q_rnd[31:0] + 32'd1;

	// Sequence the division
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						neg_q   <= req.num[63] ^ req.den[63];
						nm_q    <= req.num[63] ? 64'(-req.num) : req.num;
						dm_q    <= req.den[63] ? 64'(-req.den) : req.den;
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					ovf_q   <= num_w[95:0] >= (lim_w << (FRAC_BITS + 1));
					rem_q   <= {1'b0, num_w[95:32]};
					sh_q    <= num_w[31:0];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= ((96'(nm_q)) >= lim_w) ? D_END : D_RUN;
				end
				D_RUN: begin
					if (rem_sh >= {1'b0, dm_q}) begin
						rem_q <= rem_sh - {1'b0, dm_q};
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[30:0], 1'b0};
					end
					sh_q  <= {sh_q[30:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31)
						state_q <= D_END;
				end
				D_END: begin
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Form the rounded, saturated quotient
	always_comb begin
		rsp.done = (state_q == D_END);
		if (ovf_q)
			rsp.quo = neg_q ? S32_MIN : S32_MAX;
		else if (!neg_q)
			rsp.quo = (q_rnd[32:31] != 2'b00) ? S32_MAX : signed'(q_rnd[31:0]);
		else
			rsp.quo = signed'(q_neg);
	end

endmodule

`default_nettype wire

// ===== design/kalman_cv_tracker_2d_unit.sv =====
// Top level of the four-state constant-velocity tracker.
// Depends on kct_pkg, kct_mul and kct_div.
//
// Use: one input beat (in_valid/in_stall) carries an action and its
// operands; each beat gives exactly one result beat (out_valid/out_stall)
// with the estimate and the singular flag. The APB port sets the six
// variance registers at byte addresses 0..20; pready is always high.
// Init seeds the state directly; predict runs 36 products on the shared
// multiplier, then the output load; update runs eight gain divisions
// through the one-bit-per-cycle divider, each after its numerator
// products (a division whose quotient overflows skips the bit-serial
// steps), plus 42 more products. A singular update ends after the
// determinant products, an unused action goes straight to the output load.
// The block takes one item at a time: in_stall stays high from acceptance
// until the result sits in the output register.
// Reset clears the state, covariance and predicted measurement to zero
// and loads the register defaults. When the receiver stalls, the result
// holds in the output register and the next item may be accepted; its
// result waits until the register is free.
`default_nettype none

module kalman_cv_tracker_2d_unit
	import kct_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         action,
	input  wire logic signed [31:0] meas_x,
	input  wire logic signed [31:0] meas_y,
	input  wire logic [23:0]        step_time,
	input  wire logic               has_measurement,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      est_pos_x,
	output logic signed [31:0]      est_pos_y,
	output logic signed [31:0]      est_vel_x,
	output logic signed [31:0]      est_vel_y,
	output logic                    singular,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_PVEC, S_PFP, S_PPC, S_US, S_UDET,
		S_UGAIN, S_UDIV, S_USV, S_UCOV, S_FIN
	} state_t;

	state_t state_q;
	logic   ph_q;
	logic   k_q;
	logic   sing_q;
	logic [3:0] e_q;

	logic [31:0] cfg_q [NUM_REGS];

	logic signed [31:0] sv_q   [4];
	logic signed [31:0] cov_q  [16];
	logic signed [31:0] pm_q   [2];
	logic signed [31:0] pv_q   [4];
	logic signed [31:0] pc_q   [16];
	logic signed [31:0] fp_q   [16];
	logic signed [31:0] gain_q [8];
	logic signed [31:0] adj_q  [4];

	logic [1:0]         act_q;
	logic signed [31:0] mx_q;
	logic signed [31:0] my_q;
	logic [23:0]        dt_q;
	logic               has_q;

	logic signed [63:0] t0_q;
	logic signed [63:0] det_q;

	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [63:0] prod;
	logic signed [63:0] mq_p;
	logic signed [63:0] mq_t;
	logic signed [65:0] sum;
	logic signed [31:0] noise;
	logic signed [31:0] inn0;
	logic signed [31:0] inn1;
	logic signed [63:0] det_w;
	logic [2:0]         ridx;
	logic               cfg_wr;
	logic               consume;

	kct_div_req_t div_req;
	kct_div_rsp_t div_rsp;

	kct_mul u_mul (
		.clk  (clk),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	kct_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall = (state_q != S_IDLE);
	assign consume  = ph_q;
	assign mq_p     = mq(prod);
	assign mq_t     = mq(t0_q);
	assign det_w    = t0_q - prod;
	assign noise    = e_q[3] ? reg_val(cfg_q[REG_PROC_VEL]) : reg_val(cfg_q[REG_PROC_POS]);
	assign inn0     = has_q ? sat32(66'(mx_q) - 66'(pm_q[0])) : '0;
	assign inn1     = has_q ? sat32(66'(my_q) - 66'(pm_q[1])) : '0;

	// Start a division once both numerator products are in
	assign div_req.start = (state_q == S_UGAIN) && ph_q && k_q;
	assign div_req.num   = t0_q + prod;
	assign div_req.den   = det_q;

	// APB register file
	assign pready = 1'b1;
	assign ridx   = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (ridx < 3'(NUM_REGS)) ? cfg_q[ridx] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_INIT_POS] <= 32'd655;
			cfg_q[REG_INIT_VEL] <= 32'd196608;
			cfg_q[REG_PROC_POS] <= 32'd65536;
			cfg_q[REG_PROC_VEL] <= 32'd98304;
			cfg_q[REG_MEAS_X]   <= 32'd15;
			cfg_q[REG_MEAS_Y]   <= 32'd15;
		end else if (cfg_wr && (ridx < 3'(NUM_REGS))) begin
			cfg_q[ridx] <= pwdata;
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_PVEC: begin
				op_a = sv_q[e_q[1:0] + 2'd2];
				op_b = signed'(32'(dt_q));
			end
			S_PFP: begin
				op_a = cov_q[{~e_q[3], e_q[2:0]}];
				op_b = signed'(32'(dt_q));
			end
			S_PPC: begin
				op_a = fp_q[{e_q[3:2], e_q[1:0] + 2'd2}];
				op_b = signed'(32'(dt_q));
			end
			S_UDET: begin
				op_a = k_q ? adj_q[1] : adj_q[3];
				op_b = k_q ? adj_q[2] : adj_q[0];
			end
			S_UGAIN: begin
				op_a = pc_q[{e_q[2:1], 1'b0, k_q}];
				op_b = adj_q[{k_q, e_q[0]}];
			end
			S_USV: begin
				op_a = gain_q[{e_q[1:0], k_q}];
				op_b = k_q ? inn1 : inn0;
			end
			S_UCOV: begin
				op_a = gain_q[{e_q[3:2], k_q}];
				op_b = pc_q[{1'b0, k_q, e_q[1:0]}];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// Accumulate the entry for the current step
	always_comb begin
		unique case (state_q)
			S_PVEC:  sum = 66'(sv_q[e_q[1:0]]) + (e_q[1] ? 66'sd0 : 66'(mq_p));
			S_PFP:   sum = 66'(cov_q[e_q]) + (e_q[3] ? 66'sd0 : 66'(mq_p));
			S_PPC:   sum = 66'(fp_q[e_q]) + (e_q[1] ? 66'sd0 : 66'(mq_p))
				+ ((e_q[3:2] == e_q[1:0]) ? 66'(noise) : 66'sd0);
			S_USV:   sum = 66'(pv_q[e_q[1:0]]) + 66'(mq_t) + 66'(mq_p);
			S_UCOV:  sum = 66'(pc_q[e_q]) - 66'(mq_t) - 66'(mq_p);
			default: sum = '0;
		endcase
	end

	// Sequencer, state storage and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ph_q      <= 1'b0;
			k_q       <= 1'b0;
			e_q       <= '0;
			sing_q    <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				sv_q[i] <= '0;
				pv_q[i] <= '0;
			end
			for (int i = 0; i < 16; i++) begin
				cov_q[i] <= '0;
				pc_q[i]  <= '0;
			end
			pm_q[0] <= '0;
			pm_q[1] <= '0;
		end else begin
			// Drop the result once the receiver takes it, unless a new one loads
			if (out_valid && !out_stall && state_q != S_FIN)
				out_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q  <= action;
						mx_q   <= meas_x;
						my_q   <= meas_y;
						dt_q   <= step_time;
						has_q  <= has_measurement;
						ph_q   <= 1'b0;
						k_q    <= 1'b0;
						e_q    <= '0;
						sing_q <= 1'b0;
						unique case (action)
							ACT_INIT:    state_q <= S_INIT;
							ACT_PREDICT: state_q <= S_PVEC;
							ACT_UPDATE:  state_q <= S_US;
							default:     state_q <= S_FIN;
						endcase
					end
				end
				S_INIT: begin
					// Seed a diagonal covariance and a still target at the measurement
					for (int i = 0; i < 16; i++) begin
						if (i == 0 || i == 5) begin
							cov_q[i] <= reg_val(cfg_q[REG_INIT_POS]);
							pc_q[i]  <= reg_val(cfg_q[REG_INIT_POS]);
						end else if (i == 10 || i == 15) begin
							cov_q[i] <= reg_val(cfg_q[REG_INIT_VEL]);
							pc_q[i]  <= reg_val(cfg_q[REG_INIT_VEL]);
						end else begin
							cov_q[i] <= '0;
							pc_q[i]  <= '0;
						end
					end
					sv_q[0] <= mx_q;
					sv_q[1] <= my_q;
					sv_q[2] <= '0;
					sv_q[3] <= '0;
					pv_q[0] <= mx_q;
					pv_q[1] <= my_q;
					pv_q[2] <= '0;
					pv_q[3] <= '0;
					state_q <= S_FIN;
				end
				S_PVEC: begin
					ph_q <= ~ph_q;
					if (consume) begin
						pv_q[e_q[1:0]] <= sat32(sum);
						if (!e_q[1])
							pm_q[e_q[0]] <= sat32(sum);
						e_q <= (e_q[1:0] == 2'd3) ? 4'd0 : e_q + 4'd1;
						if (e_q[1:0] == 2'd3)
							state_q <= S_PFP;
					end
				end
				S_PFP: begin
					ph_q <= ~ph_q;
					if (consume) begin
						fp_q[e_q] <= sat32(sum);
						e_q       <= e_q + 4'd1;
						if (e_q == 4'd15)
							state_q <= S_PPC;
					end
				end
				S_PPC: begin
					ph_q <= ~ph_q;
					if (consume) begin
						pc_q[e_q] <= sat32(sum);
						e_q       <= e_q + 4'd1;
						if (e_q == 4'd15)
							state_q <= S_FIN;
					end
				end
				S_US: begin
					// Innovation covariance and its adjugate
					adj_q[3] <= satsym(33'(pc_q[0]) + 33'(reg_val(cfg_q[REG_MEAS_X])));
					adj_q[1] <= -satsym(33'(pc_q[1]));
					adj_q[2] <= -satsym(33'(pc_q[4]));
					adj_q[0] <= satsym(33'(pc_q[5]) + 33'(reg_val(cfg_q[REG_MEAS_Y])));
					state_q  <= S_UDET;
				end
				S_UDET: begin
					ph_q <= ~ph_q;
					if (consume) begin
						if (!k_q) begin
							t0_q <= prod;
							k_q  <= 1'b1;
						end else begin
							k_q   <= 1'b0;
							det_q <= det_w;
							if (det_w == 64'sd0) begin
								sing_q  <= 1'b1;
								state_q <= S_FIN;
							end else begin
								e_q     <= '0;
								state_q <= S_UGAIN;
							end
						end
					end
				end
				S_UGAIN: begin
					ph_q <= ~ph_q;
					if (consume) begin
						if (!k_q) begin
							t0_q <= prod;
							k_q  <= 1'b1;
						end else begin
							k_q     <= 1'b0;
							state_q <= S_UDIV;
						end
					end
				end
				S_UDIV: begin
					ph_q <= 1'b0;
					if (div_rsp.done) begin
						gain_q[e_q[2:0]] <= div_rsp.quo;
						e_q <= (e_q[2:0] == 3'd7) ? 4'd0 : e_q + 4'd1;
						state_q <= (e_q[2:0] == 3'd7) ? S_USV : S_UGAIN;
					end
				end
				S_USV: begin
					ph_q <= ~ph_q;
					if (consume) begin
						if (!k_q) begin
							t0_q <= prod;
							k_q  <= 1'b1;
						end else begin
							k_q            <= 1'b0;
							sv_q[e_q[1:0]] <= sat32(sum);
							e_q <= (e_q[1:0] == 2'd3) ? 4'd0 : e_q + 4'd1;
							if (e_q[1:0] == 2'd3)
								state_q <= S_UCOV;
						end
					end
				end
				S_UCOV: begin
					ph_q <= ~ph_q;
					if (consume) begin
						if (!k_q) begin
							t0_q <= prod;
							k_q  <= 1'b1;
						end else begin
							k_q        <= 1'b0;
							cov_q[e_q] <= sat32(sum);
							e_q        <= e_q + 4'd1;
							if (e_q == 4'd15)
								state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					// Load the result once the output register is free
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						singular  <= sing_q;
						if (act_q == ACT_PREDICT || sing_q) begin
							est_pos_x <= pv_q[0];
							est_pos_y <= pv_q[1];
							est_vel_x <= pv_q[2];
							est_vel_y <= pv_q[3];
						end else begin
							est_pos_x <= sv_q[0];
							est_pos_y <= sv_q[1];
							est_vel_x <= sv_q[2];
							est_vel_y <= sv_q[3];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/kct_checker.sv =====
// Port-level checker for the tracker, bound to the top level.
// Depends on kalman_cv_tracker_2d_unit_defines.svh.
`default_nettype none

`include "kalman_cv_tracker_2d_unit_defines.svh"

module kct_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic signed [31:0] est_pos_x,
	input wire logic               singular
);

	// An accepted beat keeps the block busy on the next cycle
	`KCT_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "not busy after accept")

	// No result can appear on the cycle right after acceptance
	`KCT_ASSERT(a_no_instant_result, in_valid && !in_stall |=> !$rose(out_valid), "result too early")

	// A stalled result beat holds
	`KCT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(est_pos_x) && $stable(singular), "stalled result changed")

	// Reset empties the output register
	`KCT_ASSERT_RST(a_reset_empty, !arst_n |=> !out_valid, "output valid in reset")

endmodule

bind kalman_cv_tracker_2d_unit kct_checker u_kct_checker (.*);

`default_nettype wire

// ===== dv/tb_kalman_cv_tracker_2d_unit.sv =====
// Self-checking bench for the 2D constant-velocity tracker: directed table, then random phases.
// Depends on kct_pkg and the kalman_cv_tracker_2d_unit RTL; a built-in predictor checks every beat.
`default_nettype none

module tb_kalman_cv_tracker_2d_unit
	import kct_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct {
		int px, py, vx, vy;
		bit sing;
	} est_t;

	typedef struct {
		logic [1:0] act;
		int         mx, my, dt;
		bit         has, known;
		est_t       want;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid, in_stall;
	logic [1:0]         action;
	logic signed [31:0] meas_x, meas_y;
	logic [23:0]        step_time;
	logic               has_measurement;
	logic               out_valid, out_stall;
	logic signed [31:0] est_pos_x, est_pos_y, est_vel_x, est_vel_y;
	logic               singular;
	logic               psel, penable, pwrite;
	logic [4:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               pready;

	kalman_cv_tracker_2d_unit uut (.*);

	always #6 clk = ~clk;

	// Tracker mirror: registers, corrected and predicted state
	logic [31:0] regs[6];
	int trk_st[4], trk_cov[16], trk_pm[2], trk_pst[4], trk_pcov[16];
	est_t est_q[$];
	int   n_err = 0, n_acc = 0, n_res = 0, n_sing = 0;
	bit   long_hold_done = 0;

	function automatic int clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return int'(v);
	endfunction

	function automatic int clipsym(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483647) return -32'sh7FFF_FFFF;
		return int'(v);
	endfunction

	function automatic longint qmul(int a, int b);
		longint s;
		s = longint'(a) * longint'(b) + (64'sd1 <<< (FRAC_BITS - 1));
		return s >>> FRAC_BITS;
	endfunction

	function automatic int reg_use(int i);
		return regs[i][31] ? 32'sh7FFF_FFFF : int'(regs[i]);
	endfunction

	// Gain quotient n*2^F/d, rounded half away from zero, saturated
	function automatic int gain_div(longint n, longint d);
		bit                neg;
		longint unsigned   nm, dm, q, r;
		neg = (n < 0) != (d < 0);
		nm = n < 0 ? 64'd0 - n : n;
		dm = d < 0 ? 64'd0 - d : d;
		q = nm / dm;
		r = nm % dm;
		if ((q >> (31 - FRAC_BITS)) != 0) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		for (int i = 0; i <= FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= dm) begin
				r = r - dm;
				q = q | 64'd1;
			end
		end
		q = (q + 64'd1) >> 1;
		if (!neg) return q > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : int'(q);
		if (q > 64'h8000_0000) return 32'sh8000_0000;
		return int'(-longint'(q));
	endfunction

	task automatic track_step(input logic [1:0] act, input int mx, my, dt, input bit has,
			output est_t e);
		int f[16], fp[16], gn[8], adj[4], inv[2];
		int s00, s01, s10, s11;
		longint s, det;
		bit sing;
		sing = 0;
		if (act == ACT_INIT) begin
			trk_cov = '{default: 0};
			trk_st = '{mx, my, 0, 0};
			trk_cov[0] = reg_use(REG_INIT_POS);
			trk_cov[5] = reg_use(REG_INIT_POS);
			trk_cov[10] = reg_use(REG_INIT_VEL);
			trk_cov[15] = reg_use(REG_INIT_VEL);
			trk_pst = trk_st;
			trk_pcov = trk_cov;
		end else if (act == ACT_PREDICT) begin
			f = '{default: 0};
			f[0] = 1 << FRAC_BITS; f[5] = f[0]; f[10] = f[0]; f[15] = f[0];
			f[2] = dt; f[7] = dt;
			for (int i = 0; i < 4; i++) begin
				s = 0;
				for (int k = 0; k < 4; k++) s += qmul(f[i*4+k], trk_st[k]);
				trk_pst[i] = clip32(s);
			end
			for (int i = 0; i < 16; i++) begin
				s = 0;
				for (int k = 0; k < 4; k++) s += qmul(f[(i/4)*4+k], trk_cov[k*4+i%4]);
				fp[i] = clip32(s);
			end
			for (int i = 0; i < 16; i++) begin
				s = 0;
				for (int k = 0; k < 4; k++) s += qmul(fp[(i/4)*4+k], f[(i%4)*4+k]);
				if (i / 4 == i % 4) s += reg_use(i < 8 ? REG_PROC_POS : REG_PROC_VEL);
				trk_pcov[i] = clip32(s);
			end
			trk_pm = '{trk_pst[0], trk_pst[1]};
		end else if (act == ACT_UPDATE) begin
			s00 = clipsym(longint'(trk_pcov[0]) + reg_use(REG_MEAS_X));
			s01 = clipsym(trk_pcov[1]);
			s10 = clipsym(trk_pcov[4]);
			s11 = clipsym(longint'(trk_pcov[5]) + reg_use(REG_MEAS_Y));
			det = longint'(s00) * s11 - longint'(s01) * s10;
			if (det == 0) begin
				sing = 1;
			end else begin
				adj = '{s11, -s01, -s10, s00};
				for (int i = 0; i < 8; i++) begin
					s = 0;
					for (int k = 0; k < 2; k++)
						s += longint'(trk_pcov[(i/2)*4+k]) * adj[k*2+i%2];
					gn[i] = gain_div(s, det);
				end
				inv[0] = has ? clip32(longint'(mx) - trk_pm[0]) : 0;
				inv[1] = has ? clip32(longint'(my) - trk_pm[1]) : 0;
				for (int i = 0; i < 4; i++)
					trk_st[i] = clip32(longint'(trk_pst[i]) + qmul(gn[i*2], inv[0])
						+ qmul(gn[i*2+1], inv[1]));
				for (int i = 0; i < 16; i++) begin
					s = trk_pcov[i];
					for (int k = 0; k < 2; k++) s -= qmul(gn[(i/4)*2+k], trk_pcov[k*4+i%4]);
					trk_cov[i] = clip32(s);
				end
			end
		end
		if (act == ACT_PREDICT || sing)
			e = '{trk_pst[0], trk_pst[1], trk_pst[2], trk_pst[3], sing};
		else
			e = '{trk_st[0], trk_st[1], trk_st[2], trk_st[3], 1'b0};
	endtask

	// APB write: setup then access, update the mirror at the write edge
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		regs[idx] = val;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(input logic [31:0] v0, v1, v2, v3, v4, v5);
		apb_write(REG_INIT_POS, v0);
		apb_write(REG_INIT_VEL, v1);
		apb_write(REG_PROC_POS, v2);
		apb_write(REG_PROC_VEL, v3);
		apb_write(REG_MEAS_X, v4);
		apb_write(REG_MEAS_Y, v5);
	endtask

	// Offer one beat after a random gap; ends at a falling edge with valid still high
	task automatic send_beat(input logic [1:0] act, input int mx, my, dt, input bit has,
			input bit known, input est_t want);
		int   r, gap;
		est_t e;
		r = $urandom_range(0, 99);
		gap = r < 50 ? 0 : (r < 92 ? $urandom_range(1, 4) : $urandom_range(20, 200));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act; meas_x <= mx; meas_y <= my;
		step_time <= dt[23:0]; has_measurement <= has;
		do @(posedge clk); while (in_stall);
		track_step(act, mx, my, dt, has, e);
		est_q.push_back(known ? want : e);
		n_acc++;
		@(negedge clk);
	endtask

	task automatic drain_idle();
		in_valid <= 1'b0;
		while (est_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	function automatic int rand_pos();
		if ($urandom_range(0, 9) < 7) return int'($urandom) >>> $urandom_range(6, 16);
		return int'($urandom);
	endfunction

	// Mostly init / predict / update cycles with random content, some noise
	task automatic random_phase(input int count, input bit pause_mid);
		logic [1:0] act, last;
		int dt;
		est_t none;
		last = ACT_UPDATE;
		none = '{0, 0, 0, 0, 0};
		for (int n = 0; n < count; n++) begin
			if (pause_mid && n == count / 2) drain_idle();
			if ($urandom_range(0, 99) < 12) begin
				act = $urandom_range(0, 3);
			end else if (n == 0 || $urandom_range(0, 39) == 0) begin
				act = ACT_INIT;
			end else begin
				act = (last == ACT_PREDICT) ? ACT_UPDATE : ACT_PREDICT;
			end
			dt = $urandom_range(0, 9) == 0 ? int'($urandom & 32'hFF_FFFF)
				: $urandom_range(0, 32'h2_0000);
			send_beat(act, rand_pos(), rand_pos(), dt, $urandom_range(0, 9) != 0, 1'b0, none);
			last = act;
		end
	endtask

	// Receiver: random stall runs, plus one long hold-off
	initial begin
		int run;
		bit stall_run;
		run = 0;
		stall_run = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!long_hold_done && n_acc >= 200) begin
				long_hold_done = 1;
				out_stall <= 1'b1;
				for (int c = 0; c < 3000; c++) @(negedge clk);
				out_stall <= 1'b0;
				run = 0;
			end else begin
				if (run == 0) begin
					stall_run = $urandom_range(0, 1);
					if (!stall_run) run = $urandom_range(1, 30);
					else run = $urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
						: $urandom_range(20, 150);
				end
				out_stall <= stall_run;
				run--;
			end
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		est_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (est_q.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				n_err++;
			end else begin
				e = est_q.pop_front();
				n_res++;
				if (singular) n_sing++;
				if (est_pos_x !== e.px) begin
					$display("%0t: est_pos_x exp %h got %h", $time, e.px, est_pos_x);
					n_err++;
				end
				if (est_pos_y !== e.py) begin
					$display("%0t: est_pos_y exp %h got %h", $time, e.py, est_pos_y);
					n_err++;
				end
				if (est_vel_x !== e.vx) begin
					$display("%0t: est_vel_x exp %h got %h", $time, e.vx, est_vel_x);
					n_err++;
				end
				if (est_vel_y !== e.vy) begin
					$display("%0t: est_vel_y exp %h got %h", $time, e.vy, est_vel_y);
					n_err++;
				end
				if (singular !== e.sing) begin
					$display("%0t: singular exp %b got %b", $time, e.sing, singular);
					n_err++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#60000000;
		$display("[kalman_cv_tracker_2d_unit] ERROR");
		$finish;
	end

	initial begin
		row_t dir_tab[15];
		est_t none;
		none = '{0, 0, 0, 0, 0};
		dir_tab = '{
			'{ACT_UPDATE, 32'sh1_0000, -32'sh1_0000, 0, 1, 0, none},
			'{ACT_INIT, S32_MAX, S32_MIN, 0, 0, 1, '{S32_MAX, S32_MIN, 0, 0, 0}},
			'{ACT_NONE, 5, 7, 9, 1, 1, '{S32_MAX, S32_MIN, 0, 0, 0}},
			'{ACT_PREDICT, 0, 0, 0, 0, 0, none},
			'{ACT_PREDICT, 0, 0, 32'hFF_FFFF, 0, 0, none},
			'{ACT_UPDATE, 0, 0, 0, 0, 0, none},
			'{ACT_UPDATE, S32_MIN, S32_MAX, 0, 1, 0, none},
			'{ACT_INIT, 0, 0, 0, 1, 1, '{0, 0, 0, 0, 0}},
			'{ACT_PREDICT, 0, 0, 32'h1_0000, 0, 0, none},
			'{ACT_UPDATE, 32'sh1_0000, 32'sh1_0000, 0, 1, 0, none},
			'{ACT_PREDICT, 0, 0, 1, 0, 0, none},
			'{ACT_UPDATE, -1, 0, 0, 1, 0, none},
			'{ACT_INIT, -1, 1, 0, 0, 1, '{-1, 1, 0, 0, 0}},
			'{ACT_PREDICT, 0, 0, 32'h8000, 1, 0, none},
			'{ACT_UPDATE, S32_MAX, S32_MAX, 0, 1, 0, none}
		};
		regs = '{32'd655, 32'd196608, 32'd65536, 32'd98304, 32'd15, 32'd15};
		trk_st = '{default: 0}; trk_cov = '{default: 0}; trk_pm = '{default: 0};
		trk_pst = '{default: 0}; trk_pcov = '{default: 0};
		arst_n = 1'b0;
		in_valid = 1'b0; action = ACT_INIT; meas_x = 0; meas_y = 0;
		step_time = 0; has_measurement = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table under reset defaults
		foreach (dir_tab[i])
			send_beat(dir_tab[i].act, dir_tab[i].mx, dir_tab[i].my, dir_tab[i].dt,
				dir_tab[i].has, dir_tab[i].known, dir_tab[i].want);
		drain_idle();

		// Zero variances: init then update is singular
		write_all(0, 0, 0, 0, 0, 0);
		send_beat(ACT_INIT, 32'sh3_0000, -32'sh2_0000, 0, 0, 1,
			'{32'sh3_0000, -32'sh2_0000, 0, 0, 0});
		send_beat(ACT_UPDATE, 32'sh1_0000, 1, 0, 1, 1,
			'{32'sh3_0000, -32'sh2_0000, 0, 0, 1});
		random_phase(150, 0);
		drain_idle();

		// Largest values, clamped to the positive range
		write_all('1, '1, '1, 32'h7FFF_FFFF, '1, 32'h8000_0000);
		random_phase(150, 0);
		drain_idle();

		// Random moderate settings, with a full drain midway
		write_all($urandom_range(0, 32'h2_0000), $urandom_range(0, 32'h8_0000),
			$urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000),
			$urandom_range(0, 32'h1000), $urandom_range(0, 32'h1000));
		random_phase(230, 1);
		drain_idle();

		// Back to defaults
		write_all(32'd655, 32'd196608, 32'd65536, 32'd98304, 32'd15, 32'd15);
		random_phase(200, 0);
		drain_idle();
		repeat (400) @(posedge clk);

		$display("Covered %0d beats accepted, %0d results checked (%0d singular)",
			n_acc, n_res, n_sing);
		$display("over default, zero, max and random variance settings; %0d mismatches", n_err);
		if (n_err == 0 && est_q.size() == 0)
			$display("[kalman_cv_tracker_2d_unit] OK");
		else
			$display("[kalman_cv_tracker_2d_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
